### sv/dks_pkg.sv
// Shared types and constants for the debounced key step adjuster.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dks_pkg;

  localparam int unsigned NUM_KEYS  = 2;
  localparam int unsigned KEY_W     = $clog2(NUM_KEYS);
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned STEP_W    = 11;
  localparam int unsigned DUTY_W    = 4;
  localparam int unsigned PER_W     = 16;
  localparam int unsigned ON1_W     = 15;
  localparam int unsigned ON2_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned OUT_DAT_W = 56;
  localparam int unsigned IN_DAT_W  = 8;

  localparam logic [CNT_W-1:0]  COUNT_MAX    = 11'd1900;
  localparam logic [CNT_W-1:0]  COUNT_MIN    = 11'd100;
  localparam logic [CNT_W-1:0]  COUNT_RESET  = 11'd1000;
  localparam logic [STEP_W-1:0] STEP_RESET   = 11'd100;
  localparam logic [DUTY_W-1:0] DUTY_RESET   = 4'd1;
  localparam logic [PER_W-1:0]  PERIOD_RESET = 16'd2000;

  // Debounce states of one key
  typedef enum logic [1:0] {
    DKS_UP      = 2'd0,
    DKS_FALLING = 2'd1,
    DKS_DOWN    = 2'd2,
    DKS_RISING  = 2'd3
  } dks_state_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE     = 2'd0,
    CFG_DUTY_FACTOR   = 2'd1,
    CFG_SECOND_PERIOD = 2'd2,
    CFG_UNUSED        = 2'd3
  } dks_cfg_idx_t;

  // Key that adds the step; the other key subtracts it
  localparam logic [KEY_W-1:0] KEY_INC = 1'b0;

  // Events confirmed by one sample
  typedef struct packed {
    logic pressed;
    logic released;
  } dks_evt_t;

endpackage : dks_pkg

`default_nettype wire

### sv/debounced_key_step_adjust_core.sv
// Top level of the debounced key step adjuster: input stage, per-key debounce
// state, shared saturating count, result register and configuration registers.
// Depends on dks_pkg, dks_key_fsm and dks_count_sat.
`timescale 1ns / 1ps
`default_nettype none

// Path: the accepting edge loads the input register; the debounce update and count
// adjust sit between it and the result register, which loads from the input
// register when the result register is empty or being drained.
// Throughput: one item per cycle, sustained, while the result side takes items.
// Reset (rst_n low, synchronous): both keys return to up, count to 1000,
// step 100, duty factor 1, second period 2000; both stages empty.
module debounced_key_step_adjust_core (
  input  wire                             clk,
  input  wire                             rst_n,
  // sample channel
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [dks_pkg::IN_DAT_W-1:0]    in_tdata,  // [0] key_level, rest zero
  input  wire  [dks_pkg::KEY_W-1:0]       in_tuser,  // [0] key_select
  // result channel
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [0] pressed_event, [1] released_event, [12:2] count_value,
  // [27:13] first_on_time, [43:28] second_period_out, [55:44] second_on_time
  output logic [dks_pkg::OUT_DAT_W-1:0]   out_tdata,
  // configuration write channel
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [dks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [dks_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import dks_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Always ready; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] step_r;
  logic [DUTY_W-1:0] duty_r;
  logic [PER_W-1:0]  period_r;
  dks_cfg_idx_t      cfg_idx;

  assign cfg_ready = 1'b1;
  assign cfg_idx   = dks_cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      duty_r   <= DUTY_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx)
        CFG_STEP_SIZE:     step_r   <= cfg_data[STEP_W-1:0];
        CFG_DUTY_FACTOR:   duty_r   <= cfg_data[DUTY_W-1:0];
        CFG_SECOND_PERIOD: period_r <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The work stage advances when the result register is empty or
  // is being drained; the input register refills whenever it advances or is
  // empty, so a waiting result does not block the next sample.
  // ---------------------------------------------------------------------------
  logic             s1_vld_r;
  logic [KEY_W-1:0] s1_key_r;
  logic             s1_lvl_r;
  logic             adv;
  logic             out_vld_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv || !s1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_key_r <= in_tuser;
      s1_lvl_r <= in_tdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Debounce state per key and the shared count.
  // ---------------------------------------------------------------------------
  dks_state_t       key_st_r [NUM_KEYS];
  dks_state_t       st_cur;
  dks_state_t       st_nxt;
  dks_evt_t         evt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             fire;

  assign fire   = s1_vld_r && adv;
  assign st_cur = key_st_r[s1_key_r];

  dks_key_fsm u_key_fsm (
    .st     (st_cur),
    .level  (s1_lvl_r),
    .st_nxt (st_nxt),
    .evt    (evt)
  );

  dks_count_sat u_count_sat (
    .cnt     (cnt_r),
    .step    (step_r),
    .en      (evt.released),
    .dec     (s1_key_r != KEY_INC),
    .cnt_nxt (cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) key_st_r[k] <= DKS_UP;
      cnt_r <= COUNT_RESET;
    end else if (fire) begin
      key_st_r[s1_key_r] <= st_nxt;
      cnt_r              <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. LED timing fields are formed from the held count and the
  // configuration; the user must change it only while the block is idle, which
  // the block itself does not enforce.
  dks_evt_t         out_evt_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [ON1_W-1:0] on1;
  logic [ON2_W-1:0] on2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_evt_r <= evt;
      out_cnt_r <= cnt_nxt;
    end
  end

  assign on1 = {{(ON1_W-CNT_W){1'b0}}, out_cnt_r} * {{(ON1_W-DUTY_W){1'b0}}, duty_r};
  assign on2 = {out_cnt_r, 1'b0};

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {on2, period_r, on1, out_cnt_r, out_evt_r.released, out_evt_r.pressed};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= COUNT_MIN) && (cnt_r <= COUNT_MAX))
    else $error("shared count left its saturation range");

  a_out_cnt_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cnt_r == cnt_r))
    else $error("held result count differs from the shared count");

  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_evt_r.pressed && out_evt_r.released))
    else $error("press and release confirmed by one sample");

  a_other_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (s1_key_r == KEY_INC)) |=> $stable(key_st_r[1]))
    else $error("sample of one key changed the other key's state");

  a_cnt_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !evt.released) |=> $stable(cnt_r))
    else $error("count moved without a confirmed release");

endmodule : debounced_key_step_adjust_core

`default_nettype wire

### sv/dks_key_fsm.sv
// Next-state logic of the four-state debounce machine for one key.
// Depends on dks_pkg for the state type and the event struct.
`timescale 1ns / 1ps
`default_nettype none

module dks_key_fsm (
  input  dks_pkg::dks_state_t st,
  input  logic                level,   // 1 released, 0 pressed
  output dks_pkg::dks_state_t st_nxt,
  output dks_pkg::dks_evt_t   evt
);
  import dks_pkg::*;

  always_comb begin
    st_nxt       = st;
    evt.pressed  = 1'b0;
    evt.released = 1'b0;
    case (st)
      DKS_UP: begin
        if (!level) st_nxt = DKS_FALLING;
      end
      DKS_FALLING: begin
        if (!level) begin
          st_nxt      = DKS_DOWN;
          evt.pressed = 1'b1;
        end else begin
          st_nxt = DKS_UP;
        end
      end
      DKS_DOWN: begin
        if (level) st_nxt = DKS_RISING;
      end
      DKS_RISING: begin
        if (level) begin
          st_nxt       = DKS_UP;
          evt.released = 1'b1;
        end else begin
          st_nxt = DKS_DOWN;
        end
      end
      default: begin
        st_nxt = DKS_UP;
      end
    endcase
  end

endmodule : dks_key_fsm

`default_nettype wire

### sv/dks_count_sat.sv
// Saturating up/down step adjust of the shared count (100..1900).
// Depends on dks_pkg for widths and limits.
`timescale 1ns / 1ps
`default_nettype none

module dks_count_sat (
  input  logic [dks_pkg::CNT_W-1:0]  cnt,
  input  logic [dks_pkg::STEP_W-1:0] step,
  input  logic                       en,
  input  logic                       dec,
  output logic [dks_pkg::CNT_W-1:0]  cnt_nxt
);
  import dks_pkg::*;

  logic [CNT_W:0] sum;
  logic [CNT_W:0] diff;

  assign sum  = {1'b0, cnt} + {1'b0, step};
  assign diff = {1'b0, cnt} - {1'b0, step};

  always_comb begin
    cnt_nxt = cnt;
    if (en) begin
      if (!dec) begin
        // clamp at the upper limit
        if (sum > {1'b0, COUNT_MAX}) cnt_nxt = COUNT_MAX;
        else                         cnt_nxt = sum[CNT_W-1:0];
      end else begin
        // borrow, zero or below the lower limit all pin to the minimum
        if (diff[CNT_W] || (diff == '0) || (diff[CNT_W-1:0] < COUNT_MIN))
          cnt_nxt = COUNT_MIN;
        else
          cnt_nxt = diff[CNT_W-1:0];
      end
    end
  end

endmodule : dks_count_sat

`default_nettype wire

### bench/debounced_key_step_adjust_core_test.sv
// Self-checking bench for debounced_key_step_adjust_core: directed key sequences,
// then random press/release traffic under several register settings and idle mixes.
// Depends on dks_pkg and the core; no files or arguments are read.
`timescale 1ns / 1ps
`default_nettype none

module debounced_key_step_adjust_core_test;
  import dks_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_TICKS = 4;     // two-stage pipe plus margin

  // One raw key sample as it enters the block
  typedef struct {
    logic key;
    logic level;
  } key_sample_t;

  // One result item, laid out exactly as out_tdata (lowest field at the bottom)
  typedef struct packed {
    logic [ON2_W-1:0] on2;
    logic [PER_W-1:0] period;
    logic [ON1_W-1:0] on1;
    logic [CNT_W-1:0] count;
    logic             released;
    logic             pressed;
  } led_reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DAT_W-1:0]  in_tdata = '0;   // [0] key_level, rest zero
  logic [KEY_W-1:0]     in_tuser = '0;   // [0] key_select
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DAT_W-1:0] out_tdata;       // pressed, released, count, on1, period, on2
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STEP_SIZE;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  debounced_key_step_adjust_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Samples waiting to be driven, and the readings the block owes us
  key_sample_t  key_samples[$];
  led_reading_t expected_readings[$];

  // Idle percentages for each side, changed only between phases
  int send_idle_pct = 35;
  int recv_idle_pct = 55;

  int   mismatches = 0;
  int   readings_seen = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;

  // Shadow copy of the debounce machines, the count and the registers
  dks_state_t       key_state[NUM_KEYS] = '{DKS_UP, DKS_UP};
  logic [CNT_W-1:0] shadow_count = COUNT_RESET;
  logic [STEP_W-1:0] step_now = STEP_RESET;
  logic [DUTY_W-1:0] duty_now = DUTY_RESET;
  logic [PER_W-1:0]  period_now = PERIOD_RESET;

  // Advance one key's debounce machine by one sample and build the reading
  function automatic led_reading_t debounce_and_adjust(input logic key, input logic level);
    led_reading_t     rd;
    dks_state_t       st;
    logic [CNT_W:0]   sum;
    st = key_state[key];
    rd = '0;
    case (st)
      DKS_UP:      if (!level) st = DKS_FALLING;
      DKS_FALLING: if (!level) begin
        st = DKS_DOWN;
        rd.pressed = 1'b1;
      end else begin
        st = DKS_UP;
      end
      DKS_DOWN:    if (level) st = DKS_RISING;
      default: if (level) begin
        st = DKS_UP;
        rd.released = 1'b1;
        // Clamp at the top on increment, at the bottom on decrement
        if (key == KEY_INC) begin
          sum = {1'b0, shadow_count} + {1'b0, step_now};
          shadow_count = (sum > COUNT_MAX) ? COUNT_MAX : sum[CNT_W-1:0];
        end else if (step_now >= shadow_count || shadow_count - step_now < COUNT_MIN) begin
          shadow_count = COUNT_MIN;
        end else begin
          shadow_count = shadow_count - step_now;
        end
      end else begin
        st = DKS_DOWN;
      end
    endcase
    key_state[key] = st;
    rd.count  = shadow_count;
    rd.on1    = shadow_count * duty_now;
    rd.period = period_now;
    rd.on2    = {shadow_count, 1'b0};
    return rd;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("reading %0d %s got %0d expected %0d",
                                readings_seen, name, got, want));
  endtask

  // Sample handshakes on the rising edge: registers, results, then new samples
  always @(posedge clk) begin : scoreboard
    led_reading_t got;
    led_reading_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        case (dks_cfg_idx_t'(cfg_index))
          CFG_STEP_SIZE:     step_now = cfg_data[STEP_W-1:0];
          CFG_DUTY_FACTOR:   duty_now = cfg_data[DUTY_W-1:0];
          CFG_SECOND_PERIOD: period_now = cfg_data[PER_W-1:0];
          default:           ;  // drop writes to the spare index
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = led_reading_t'(out_tdata);
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("reading %0d arrived with none expected", readings_seen));
        end else begin
          want = expected_readings.pop_front();
          check_field("pressed_event", got.pressed, want.pressed);
          check_field("released_event", got.released, want.released);
          check_field("count_value", got.count, want.count);
          check_field("first_on_time", got.on1, want.on1);
          check_field("second_period_out", got.period, want.period);
          check_field("second_on_time", got.on2, want.on2);
        end
        readings_seen++;
      end
      if (in_tvalid && in_tready)
        expected_readings.push_back(debounce_and_adjust(in_tuser[0], in_tdata[0]));
    end
  end

  // Sample driver: hold the item until taken, then advance or idle
  always @(negedge clk) begin : feed_samples
    key_sample_t s;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (key_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s = key_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_DAT_W-1){1'b0}}, s.level};
        in_tuser  <= s.key;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin : stall_results
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run if no channel moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_levels(input logic key, input string levels);
    key_sample_t s;
    s.key = key;
    foreach (levels[i]) begin
      s.level = (levels[i] == "1");
      key_samples.push_back(s);
    end
  endtask

  // Wait until every sample is taken and every reading is back, then let the pipe settle
  task automatic drain();
    while (key_samples.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // Called at a falling edge; leaves valid high, the caller lowers it
  task automatic write_reg(input dks_cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [15:0] step_w, input logic [15:0] duty_w,
                          input logic [15:0] period_w, input logic [15:0] spare_w);
    write_reg(CFG_STEP_SIZE, step_w);
    write_reg(CFG_DUTY_FACTOR, duty_w);
    write_reg(CFG_SECOND_PERIOD, period_w);
    write_reg(CFG_UNUSED, spare_w);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          gen_pos[NUM_KEYS];
    key_sample_t s;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: hold up, full press/release on each key, both kinds of glitch
    push_levels(0, "1");
    push_levels(0, "0011");
    push_levels(1, "0011");
    push_levels(0, "01");
    push_levels(1, "001011");
    drain();

    // Widest step: the increment clamps at the top, the decrement at the bottom
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom));
    push_levels(0, "0011");
    push_levels(1, "0011");

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      if (phase < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 55;
      end else if (phase < 4) begin
        send_idle_pct = 55;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: set_regs({5'($urandom), 11'($urandom_range(300))}, 16'($urandom),
                    16'($urandom), 16'($urandom));
        1: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom));
        2: set_regs(16'h0000, 16'h0000, 16'h0000, 16'($urandom));
        3: set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        4: set_regs({5'($urandom), 11'($urandom_range(1, 200))}, 16'($urandom),
                    16'($urandom), 16'($urandom));
        default: set_regs(16'h0001, 16'h000F, 16'($urandom), 16'($urandom));
      endcase

      // Mostly clean press/release scripts per key, interleaved, with noise mixed in
      gen_pos = '{0, 0};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s.key = $urandom_range(1);
        if ($urandom_range(99) < 85) begin
          s.level = (gen_pos[s.key] >= 2);
          gen_pos[s.key] = (gen_pos[s.key] + 1) % 4;
        end else begin
          s.level = $urandom_range(1);
        end
        key_samples.push_back(s);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/dks_pkg.sv
sv/dks_key_fsm.sv
sv/dks_count_sat.sv
sv/debounced_key_step_adjust_core.sv
bench/debounced_key_step_adjust_core_test.sv
